### src/ksw_pkg.sv
// Shared types and constants for the keypad setpoint window regulator.
// Depends on nothing; the core, the top level and the bench import it.
package ksw_pkg;

    // Most digits one entry may hold
    localparam int unsigned MAX_DIGITS = 6;

    // Regulation phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEED = 2'd1;
    localparam logic [1:0] PH_UP   = 2'd2;
    localparam logic [1:0] PH_DOWN = 2'd3;

    // Decoded key codes; 0..9 are digits
    localparam logic [3:0] KEY_PT  = 4'd10;
    localparam logic [3:0] KEY_EQ  = 4'd11;
    localparam logic [3:0] KEY_CLR = 4'd12;
    localparam logic [3:0] KEY_OP  = 4'd13;

    // Configuration register indexes
    localparam logic [1:0] CFG_MV_SCALE    = 2'd0;
    localparam logic [1:0] CFG_UNDER       = 2'd1;
    localparam logic [1:0] CFG_OVER        = 2'd2;
    localparam logic [1:0] CFG_PASS_TOTAL  = 2'd3;

    // Reset values
    localparam logic [15:0] MV_SCALE_RST   = 16'd9080;
    localparam logic [7:0]  UNDER_RST      = 8'd4;
    localparam logic [7:0]  OVER_RST       = 8'd8;
    localparam logic [2:0]  PASS_TOTAL_RST = 3'd5;
    localparam logic [2:0]  POINT_NONE     = 3'd5;
    localparam logic [7:0]  DRIVE_RST      = 8'd75;
    localparam logic [15:0] SAT16          = 16'hFFFF;

    typedef struct packed {
        logic [15:0] mv_scale_x256;
        logic [7:0]  under_margin;
        logic [7:0]  over_margin;
        logic [2:0]  pass_total;
    } cfg_t;

    typedef struct packed {
        logic       mode;
        logic [5:0] key_code;
        logic [7:0] adc_sample;
    } item_t;

    typedef struct packed {
        logic        dac_write;
        logic [7:0]  dac_code;
        logic [15:0] measured_mv;
        logic [15:0] setpoint_value;
        logic        regulating;
    } result_t;

    // Keypad layout, indexed by inverted row and column.
    // Rows from the top: 7 8 9 +, 4 5 6 -, 1 2 3 *, 0 . = clear
    function automatic logic [3:0] key_lookup(input logic [1:0] r, input logic [1:0] c);
        logic [3:0] k;
        k = KEY_OP;
        case ({r, c})
            4'h0: k = 4'd7;
            4'h1: k = 4'd8;
            4'h2: k = 4'd9;
            4'h4: k = 4'd4;
            4'h5: k = 4'd5;
            4'h6: k = 4'd6;
            4'h8: k = 4'd1;
            4'h9: k = 4'd2;
            4'hA: k = 4'd3;
            4'hC: k = 4'd0;
            4'hD: k = KEY_PT;
            4'hE: k = KEY_EQ;
            4'hF: k = KEY_CLR;
            default: k = KEY_OP;
        endcase
        return k;
    endfunction

endpackage

### src/ksw_if.sv
// Valid/ready channel interfaces for input words and result words.
// Depends on nothing.
interface ksw_item_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [5:0] key_code;
    logic [7:0] adc_sample;

    modport source (output valid, output mode, output key_code, output adc_sample,
                    input ready);
    modport sink   (input valid, input mode, input key_code, input adc_sample,
                    output ready);
endinterface

interface ksw_result_if;
    logic        valid;
    logic        ready;
    logic        dac_write;
    logic [7:0]  dac_code;
    logic [15:0] measured_mv;
    logic [15:0] setpoint_value;
    logic        regulating;

    modport source (output valid, output dac_write, output dac_code, output measured_mv,
                    output setpoint_value, output regulating, input ready);
    modport sink   (input valid, input dac_write, input dac_code, input measured_mv,
                    input setpoint_value, input regulating, output ready);
endinterface

### src/ksw_core.sv
// Entry and regulation state with the combinational step logic for one word.
// Depends on ksw_pkg.
module ksw_core
    import ksw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [2:0]  digit_count_reg, digit_count_next;
    logic [2:0]  point_index_reg, point_index_next;
    logic [15:0] setpoint_reg, setpoint_next;
    logic [7:0]  drive_reg, drive_next;
    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  passes_reg, passes_next;
    logic [15:0] last_mv_reg, last_mv_next;
    logic        dac_write;

    // Key decode
    logic [2:0]  row, col;
    logic        key_ok;
    logic [3:0]  key;
    assign row    = item.key_code[5:3];
    assign col    = item.key_code[2:0];
    assign key_ok = !row[2] && !col[2];
    assign key    = key_lookup(~row[1:0], ~col[1:0]);

    // Digit append with saturation
    logic [19:0] digit_acc;
    logic [15:0] digit_sat;
    assign digit_acc = 20'(setpoint_reg) * 20'd10 + 20'(key);
    assign digit_sat = (digit_acc > 20'(SAT16)) ? SAT16 : digit_acc[15:0];

    // Equals: fraction digit count and millivolt scaling
    logic [2:0]  pos, frac_k;
    logic [9:0]  factor;
    logic [25:0] scaled;
    logic [15:0] scaled_sat;
    assign pos    = point_index_reg + 3'd1;
    assign frac_k = (digit_count_reg > pos) ? (digit_count_reg - pos) : 3'd0;
    always_comb
    begin
        case (frac_k)
            3'd0:    factor = 10'd1000;
            3'd1:    factor = 10'd100;
            3'd2:    factor = 10'd10;
            3'd3:    factor = 10'd1;
            default: factor = 10'd0;
        endcase
    end
    assign scaled     = 26'(setpoint_reg) * 26'(factor);
    assign scaled_sat = (scaled > 26'(SAT16)) ? SAT16 : scaled[15:0];

    // Sample conversion and window test
    logic [23:0] mv_prod;
    logic [15:0] mv;
    logic        below, above;
    logic [7:0]  base_code;
    logic [2:0]  passes_dec;
    assign mv_prod    = 24'(item.adc_sample) * 24'(cfg.mv_scale_x256);
    assign mv         = mv_prod[23:8];
    assign below      = (17'(mv) + 17'(cfg.under_margin)) < 17'(setpoint_reg);
    assign above      = 17'(mv) > (17'(setpoint_reg) + 17'(cfg.over_margin));
    assign base_code  = (phase_reg == PH_SEED) ? item.adc_sample : drive_reg;
    assign passes_dec = passes_reg - 3'd1;

    // Next state
    always_comb
    begin
        digit_count_next = digit_count_reg;
        point_index_next = point_index_reg;
        setpoint_next    = setpoint_reg;
        drive_next       = drive_reg;
        phase_next       = phase_reg;
        passes_next      = passes_reg;
        last_mv_next     = last_mv_reg;
        dac_write        = 1'b0;
        if (item.mode)
        begin
            last_mv_next = mv;
            if (phase_reg == PH_IDLE || passes_reg == 3'd0)
            begin
                phase_next = PH_IDLE;
            end
            else
            begin
                drive_next = base_code;
                if (phase_reg != PH_DOWN && below)
                begin
                    drive_next = base_code + 8'd1;
                    phase_next = PH_UP;
                    dac_write  = 1'b1;
                end
                else if (above)
                begin
                    drive_next = base_code - 8'd1;
                    phase_next = PH_DOWN;
                    dac_write  = 1'b1;
                end
                else
                begin
                    // in the window: pass done
                    passes_next = passes_dec;
                    phase_next  = (passes_dec != 3'd0) ? PH_SEED : PH_IDLE;
                end
            end
        end
        else if (key_ok)
        begin
            if (key <= 4'd9)
            begin
                if (32'(digit_count_reg) < MAX_DIGITS)
                begin
                    setpoint_next    = digit_sat;
                    digit_count_next = digit_count_reg + 3'd1;
                end
            end
            else if (key == KEY_PT)
            begin
                point_index_next = digit_count_reg - 3'd1;
            end
            else if (key == KEY_EQ)
            begin
                setpoint_next = scaled_sat;
                passes_next   = cfg.pass_total;
                phase_next    = (cfg.pass_total != 3'd0) ? PH_SEED : PH_IDLE;
            end
            else if (key == KEY_CLR)
            begin
                digit_count_next = 3'd0;
                point_index_next = POINT_NONE;
                setpoint_next    = 16'd0;
                passes_next      = 3'd0;
                phase_next       = PH_IDLE;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= 3'd0;
            point_index_reg <= POINT_NONE;
            setpoint_reg    <= 16'd0;
            drive_reg       <= DRIVE_RST;
            phase_reg       <= PH_IDLE;
            passes_reg      <= 3'd0;
            last_mv_reg     <= 16'd0;
        end
        else if (step_en)
        begin
            digit_count_reg <= digit_count_next;
            point_index_reg <= point_index_next;
            setpoint_reg    <= setpoint_next;
            drive_reg       <= drive_next;
            phase_reg       <= phase_next;
            passes_reg      <= passes_next;
            last_mv_reg     <= last_mv_next;
        end
    end

    // Result word reflects the state after this step
    assign result.dac_write      = dac_write;
    assign result.dac_code       = drive_next;
    assign result.measured_mv    = last_mv_next;
    assign result.setpoint_value = setpoint_next;
    assign result.regulating     = (passes_next != 3'd0);

endmodule

### src/keypad_setpoint_window_regulator.sv
// Top level: input register, configuration registers, step core, result register.
// Depends on ksw_pkg, ksw_item_if, ksw_result_if and ksw_core.
//
// Usage:
//   item   - valid/ready input channel; each word is a key event (mode 0,
//            key_code) or a converter sample (mode 1, adc_sample).
//   result - valid/ready output channel; exactly one word per input word,
//            in order, carrying the DAC code, last millivolt reading,
//            setpoint and regulating flag after that word.
//   cfg_we / cfg_index / cfg_data - register write port, one write per
//            cycle with cfg_we high; write only while no words are in flight.
// The word sits in the input register while the step logic works on it, and the
// result register loads its result when the result side can advance. Throughput
// is one word per cycle while results drain; the sample and setpoint multipliers
// run side by side, each ahead of a compare.
// When the result side stalls, the result register holds its word, the
// input register holds the next one, and ready drops only when both are full.
// Reset clears the entry, stops regulation, sets the DAC code to 75 and
// loads the register defaults; both pipeline stages come up empty.
module keypad_setpoint_window_regulator
    import ksw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ksw_item_if.sink      item,
    ksw_result_if.source  result,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_reg;
    logic    res_valid_reg;
    result_t step_res;
    logic    advance;
    logic    step_en;
    logic    item_take;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mv_scale_x256 <= MV_SCALE_RST;
            cfg_reg.under_margin  <= UNDER_RST;
            cfg_reg.over_margin   <= OVER_RST;
            cfg_reg.pass_total    <= PASS_TOTAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MV_SCALE:   cfg_reg.mv_scale_x256 <= cfg_data;
                CFG_UNDER:      cfg_reg.under_margin  <= cfg_data[7:0];
                CFG_OVER:       cfg_reg.over_margin   <= cfg_data[7:0];
                CFG_PASS_TOTAL: cfg_reg.pass_total    <= cfg_data[2:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Pipeline handshake
    assign advance    = !res_valid_reg || result.ready;
    assign step_en    = item_valid_reg && advance;
    assign item.ready = !item_valid_reg || advance;
    assign item_take  = item.valid && item.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            item_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg.mode       <= item.mode;
            item_reg.key_code   <= item.key_code;
            item_reg.adc_sample <= item.adc_sample;
        end
    end

    ksw_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (step_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_reg <= step_res;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.dac_write      = res_reg.dac_write;
    assign result.dac_code       = res_reg.dac_code;
    assign result.measured_mv    = res_reg.measured_mv;
    assign result.setpoint_value = res_reg.setpoint_value;
    assign result.regulating     = res_reg.regulating;

endmodule

### sim/keypad_setpoint_window_regulator_tb.sv
// Self-checking bench for the keypad setpoint window regulator: key entry, equals
// scaling, window regulation passes and register settings, under random idling.
// Depends on ksw_pkg, ksw_item_if, ksw_result_if and the top level in src.
`timescale 1ns / 1ps

module keypad_setpoint_window_regulator_tb;
    import ksw_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    // Expected result words, built from a cycle-free model of entry and regulation
    class regulator_scoreboard;
        cfg_t        regs;
        logic [2:0]  digits;
        logic [2:0]  point_at;
        logic [2:0]  passes_left;
        logic [15:0] setpoint;
        logic [15:0] last_mv;
        logic [7:0]  drive;
        logic [1:0]  phase;
        result_t     expected_q[$];
        int unsigned errors;
        int unsigned words_in;
        int unsigned words_out;
        int unsigned dac_writes;
        int unsigned passes_done;

        function new();
            regs = '{MV_SCALE_RST, UNDER_RST, OVER_RST, PASS_TOTAL_RST};
            clear_entry();
            drive       = DRIVE_RST;
            last_mv     = '0;
            errors      = 0;
            words_in    = 0;
            words_out   = 0;
            dac_writes  = 0;
            passes_done = 0;
        endfunction

        function void clear_entry();
            digits      = '0;
            point_at    = POINT_NONE;
            setpoint    = '0;
            passes_left = '0;
            phase       = PH_IDLE;
        endfunction

        // Keypad layout from the top row: 7 8 9 +, 4 5 6 -, 1 2 3 *, 0 . = clear
        static function logic [3:0] decode_key(input logic [2:0] row, input logic [2:0] col);
            case ({row[1:0], col[1:0]})
                4'b11_11: return 4'd7;
                4'b11_10: return 4'd8;
                4'b11_01: return 4'd9;
                4'b10_11: return 4'd4;
                4'b10_10: return 4'd5;
                4'b10_01: return 4'd6;
                4'b01_11: return 4'd1;
                4'b01_10: return 4'd2;
                4'b01_01: return 4'd3;
                4'b00_11: return 4'd0;
                4'b00_10: return KEY_PT;
                4'b00_01: return KEY_EQ;
                4'b00_00: return KEY_CLR;
                default:  return KEY_OP;
            endcase
        endfunction

        function logic [15:0] clip16(input int unsigned v);
            return (v > 32'd65535) ? SAT16 : v[15:0];
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [15:0] val);
            case (idx)
                CFG_MV_SCALE:   regs.mv_scale_x256 = val;
                CFG_UNDER:      regs.under_margin  = val[7:0];
                CFG_OVER:       regs.over_margin   = val[7:0];
                CFG_PASS_TOTAL: regs.pass_total    = val[2:0];
                default:        ;
            endcase
        endfunction

        // Advance the model by one accepted word and queue the result it gives
        function void note_word(input item_t w);
            result_t     r;
            int unsigned mv;
            int unsigned frac;
            int unsigned factor;
            logic [2:0]  pos;
            logic [3:0]  key;
            logic        below;
            logic        above;
            r.dac_write = 1'b0;
            if (w.mode) begin
                mv = (32'(w.adc_sample) * 32'(regs.mv_scale_x256)) >> 8;
                last_mv = mv[15:0];
                if (phase == PH_IDLE || passes_left == 3'd0) begin
                    phase = PH_IDLE;
                end else begin
                    // full-width compares, no wrap
                    below = (32'(last_mv) + 32'(regs.under_margin)) < 32'(setpoint);
                    above = 32'(last_mv) > (32'(setpoint) + 32'(regs.over_margin));
                    // seed loads the sample, the window test still runs on it
                    if (phase == PH_SEED)
                        drive = w.adc_sample;
                    if (phase != PH_DOWN && below) begin
                        drive = drive + 8'd1;
                        phase = PH_UP;
                        r.dac_write = 1'b1;
                    end else if (above) begin
                        drive = drive - 8'd1;
                        phase = PH_DOWN;
                        r.dac_write = 1'b1;
                    end else begin
                        passes_left = passes_left - 3'd1;
                        phase = (passes_left != 3'd0) ? PH_SEED : PH_IDLE;
                        passes_done++;
                    end
                end
            end else if (w.key_code[5:3] <= 3'd3 && w.key_code[2:0] <= 3'd3) begin
                key = decode_key(w.key_code[5:3], w.key_code[2:0]);
                if (key <= 4'd9) begin
                    if (digits < MAX_DIGITS) begin
                        setpoint = clip16(32'(setpoint) * 10 + 32'(key));
                        digits   = digits + 3'd1;
                    end
                end else if (key == KEY_PT) begin
                    point_at = digits - 3'd1;
                end else if (key == KEY_EQ) begin
                    pos  = point_at + 3'd1;
                    frac = (digits > pos) ? 32'(digits - pos) : 0;
                    case (frac)
                        0:       factor = 1000;
                        1:       factor = 100;
                        2:       factor = 10;
                        3:       factor = 1;
                        default: factor = 0;
                    endcase
                    setpoint    = clip16(32'(setpoint) * factor);
                    passes_left = regs.pass_total;
                    phase       = (passes_left != 3'd0) ? PH_SEED : PH_IDLE;
                end else if (key == KEY_CLR) begin
                    clear_entry();
                end
            end
            if (r.dac_write)
                dac_writes++;
            r.dac_code       = drive;
            r.measured_mv    = last_mv;
            r.setpoint_value = setpoint;
            r.regulating     = (passes_left != 3'd0);
            expected_q.push_back(r);
            words_in++;
        endfunction

        function void compare_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d %s expected %0d got %0d",
                             words_out, name, want, got);
            end
        endfunction

        function void check_word(input result_t got);
            result_t want;
            words_out++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d arrived with nothing outstanding", words_out);
                return;
            end
            want = expected_q.pop_front();
            compare_field("dac_write", want.dac_write, got.dac_write);
            compare_field("dac_code", want.dac_code, got.dac_code);
            compare_field("measured_mv", want.measured_mv, got.measured_mv);
            compare_field("setpoint_value", want.setpoint_value, got.setpoint_value);
            compare_field("regulating", want.regulating, got.regulating);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    ksw_item_if   item_ch();
    ksw_result_if result_ch();

    regulator_scoreboard sb = new();

    int unsigned words_sent   = 0;
    int unsigned burst_left   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned settings_run = 1;

    keypad_setpoint_window_regulator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Key code for a decoded key: first row/column position that maps to it
    function automatic logic [5:0] key_code_for(input logic [3:0] key);
        logic [5:0] code;
        for (int i = 0; i < 64; i++)
        begin
            code = i[5:0];
            if (code[5:3] <= 3'd3 && code[2:0] <= 3'd3 &&
                regulator_scoreboard::decode_key(code[5:3], code[2:0]) == key)
                return code;
        end
        return '1;
    endfunction

    // Send one word; the sender runs in bursts with random gaps between them
    task automatic send_word(input logic m, input logic [5:0] k, input logic [7:0] s);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            if (gap != 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item_ch.valid      <= 1'b1;
        item_ch.mode       <= m;
        item_ch.key_code   <= k;
        item_ch.adc_sample <= s;
        do
            @(posedge clk);
        while (!(item_ch.valid && item_ch.ready));
        burst_left--;
        words_sent++;
    endtask

    task automatic send_key(input logic [3:0] key);
        send_word(1'b0, key_code_for(key), 8'($urandom));
    endtask

    task automatic send_sample(input logic [7:0] s);
        send_word(1'b1, 6'($urandom), s);
    endtask

    // Stop sending and wait until every expected word has come back;
    // the first edge lets the monitor note the last accepted word
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_regs(input cfg_t c);
        logic [15:0] vals [4];
        logic [1:0]  idxs [4];
        drain();
        idxs = '{CFG_MV_SCALE, CFG_UNDER, CFG_OVER, CFG_PASS_TOTAL};
        vals = '{c.mv_scale_x256, 16'(c.under_margin), 16'(c.over_margin),
                 16'(c.pass_total)};
        for (int i = 0; i < 4; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            sb.set_reg(idxs[i], vals[i]);
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // Mostly complete entries followed by samples near the setpoint, plus noise
    task automatic run_random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned ndig;
        int unsigned pt_pos;
        int unsigned target;
        logic [7:0]  s;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                send_word(1'($urandom), 6'($urandom), 8'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 9) < 7)
                    send_key(KEY_CLR);
                ndig   = $urandom_range(0, 7);
                pt_pos = $urandom_range(0, ndig + 2);
                for (int d = 0; d <= ndig; d++)
                begin
                    if (d == pt_pos)
                    begin
                        send_key(KEY_PT);
                        if ($urandom_range(0, 7) == 0)
                            send_key(KEY_PT);
                    end
                    if (d < ndig)
                        send_key(4'($urandom_range(0, 9)));
                end
                if ($urandom_range(0, 9) != 0)
                    send_key(KEY_EQ);
                repeat ($urandom_range(1, 14))
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        send_key(4'($urandom_range(0, 9)));
                    end
                    else if ($urandom_range(0, 2) != 0)
                    begin
                        // aim at the code that lands near the setpoint
                        target = (sb.regs.mv_scale_x256 == 0) ? 0 :
                                 (32'(sb.setpoint) << 8) / sb.regs.mv_scale_x256;
                        target = target + $urandom_range(0, 6);
                        target = (target < 3) ? 0 : target - 3;
                        s = (target > 255) ? 8'hFF : target[7:0];
                        send_sample(s);
                    end
                    else
                    begin
                        send_sample(8'($urandom));
                    end
                end
            end
        end
    endtask

    // Receiver: stretches of always-ready, light, heavy and sparse acceptance
    initial
    begin : receiver
        int style;
        result_ch.ready <= 1'b0;
        forever
        begin
            style = $urandom_range(0, 3);
            repeat ($urandom_range(4, 64))
            begin
                @(posedge clk);
                case (style)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       result_ch.ready <= 1'($urandom);
                    default: result_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Word capture on both channels, plus the no-progress watchdog
    always @(posedge clk)
    begin : monitor
        item_t   w;
        result_t got;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                w.mode       = item_ch.mode;
                w.key_code   = item_ch.key_code;
                w.adc_sample = item_ch.adc_sample;
                sb.note_word(w);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got.dac_write      = result_ch.dac_write;
                got.dac_code       = result_ch.dac_code;
                got.measured_mv    = result_ch.measured_mv;
                got.setpoint_value = result_ch.setpoint_value;
                got.regulating     = result_ch.regulating;
                sb.check_word(got);
            end
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        cfg_t c;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_MV_SCALE;
        cfg_data           <= '0;
        item_ch.valid      <= 1'b0;
        item_ch.mode       <= 1'b0;
        item_ch.key_code   <= '0;
        item_ch.adc_sample <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed entry at reset settings
        send_word(1'b0, 6'h3F, 8'hFF);              // row and column out of range
        for (int r = 1; r < 4; r++)                 // operator keys, column 0
            send_word(1'b0, {3'(r), 3'd0}, 8'($urandom));
        send_key(KEY_EQ);                           // empty entry
        send_key(KEY_PT);                           // point before any digit
        for (int d = 1; d <= 7; d++)                // saturates, then 7th digit dropped
            send_key(4'(d));
        send_key(KEY_EQ);                           // too many fraction digits gives 0
        send_key(KEY_CLR);
        send_key(KEY_PT);                           // second point wins: 2.5
        send_key(4'd2);
        send_key(KEY_PT);
        send_key(4'd5);
        send_key(KEY_EQ);
        send_sample(8'd0);                          // seed, then step up
        send_sample(8'hFF);                         // step down to 0
        send_sample(8'hFF);                         // wraps to 255
        send_sample(8'd70);                         // below the window while stepping down, pass ends
        send_key(4'd3);                             // digit after equals
        send_key(KEY_EQ);                           // restart while regulating, saturates
        send_sample(8'hFF);                         // seed 255, step up wraps to 0
        send_key(KEY_CLR);
        send_sample(8'd128);                        // idle sample
        run_random_traffic(220);

        // Register extremes, then random settings
        write_regs('{16'hFFFF, 8'd0, 8'd0, 3'd7});
        run_random_traffic(200);
        write_regs('{16'd0, 8'd255, 8'd255, 3'd1});
        run_random_traffic(200);
        write_regs('{16'd256, 8'd2, 8'd3, 3'd3});
        run_random_traffic(200);
        repeat (3)
        begin
            c.mv_scale_x256 = $urandom_range(1500, 30000);
            c.under_margin  = 8'($urandom_range(0, 40));
            c.over_margin   = 8'($urandom_range(0, 40));
            c.pass_total    = 3'($urandom_range(1, 7));
            write_regs(c);
            run_random_traffic(190);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d words under %0d register settings: %0d DAC writes, %0d passes done",
                 sb.words_in, settings_run, sb.dac_writes, sb.passes_done);
        $display("%0d field errors, %0d results left outstanding", sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
